/* rtl/ipv4p_pkg.sv */
// Shared types and constants for the IPv4 dotted-decimal text parser.
// No dependencies; used by ipv4p_octet_check and ipv4_text_address_parser.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

    // Character codes
    localparam logic [7:0] CH_DOT       = 8'd46;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] CH_NINE      = 8'd57;
    localparam logic [7:0] DELIM_RESET  = 8'd9;    // tab

    // Octet limits
    localparam logic [9:0] OCTET_MAX    = 10'd255;
    localparam logic [2:0] OCTET_DIGITS = 3'd3;
    localparam logic [2:0] PART_LIMIT   = 3'd4;
    localparam logic [2:0] LAST_DOT     = 3'd3;
    localparam logic [9:0] DECIMAL_BASE = 10'd10;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PARTS     = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NONDIGIT  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_OVER_255  = 3'd5;

    // State of the octet being collected
    typedef struct packed {
        logic [2:0] length;     // saturates at PART_LIMIT
        logic [9:0] value;      // first three digits only
        logic       nondigit;
    } octet_t;

endpackage

`default_nettype wire

/* rtl/ipv4p_octet_check.sv */
// Classifies one finished octet into a status code.
// Depends on ipv4p_pkg (octet_t, status codes).
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_octet_check (
    input  ipv4p_pkg::octet_t octet,
    output logic [2:0]        err
);

    // Check order: empty, non-digit, too long, over 255
    always_comb begin
        priority if (octet.length == 3'd0) begin
            err = ipv4p_pkg::ST_EMPTY;
        end else if (octet.nondigit) begin
            err = ipv4p_pkg::ST_NONDIGIT;
        end else if (octet.length > ipv4p_pkg::OCTET_DIGITS) begin
            err = ipv4p_pkg::ST_TOO_LONG;
        end else if (octet.value > ipv4p_pkg::OCTET_MAX) begin
            err = ipv4p_pkg::ST_OVER_255;
        end else begin
            err = ipv4p_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

/* rtl/ipv4_text_address_parser.sv */
// Top level of the IPv4 dotted-decimal text parser.
// Depends on ipv4p_pkg and ipv4p_octet_check.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_ch[7:0], s_line_end
//  m_        out        m_valid/m_ready    m_ip_address[31:0], m_status[2:0]
//  cfg_      in         cfg_we (no wait)   cfg_wdata[7:0] -> delimiter
//
//  One character per cycle while s_ready is high. Each accepted transfer updates the line state
//  in the same edge; an end-of-line transfer loads the result register,
//  which shows the result from the next cycle on.
//  s_ready stays high while the result register is empty or being drained,
//  so no new character is accepted while a finished result waits on m_ready.
//  aresetn (synchronous) clears line state, result valid and sets the
//  delimiter to tab; the three stored octets are not cleared.

module ipv4_text_address_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_line_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_ip_address,
    output logic [2:0]  m_status,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    // Line state
    logic [7:0]          delim_reg;
    logic                skipping_reg, skipping_next;
    logic [2:0]          dot_count_reg, dot_count_next;
    ipv4p_pkg::octet_t   octet_reg, octet_next;
    logic [2:0]          first_err_reg, first_err_next;

    // First three octets of the line; no reset, each read only after a write
    logic [7:0]          store_reg [3];

    // Result register
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         addr_reg, addr_next;
    logic [2:0]          status_reg, status_next;

    logic                accept;
    logic [2:0]          octet_err;
    logic                is_digit;
    logic [3:0]          digit;
    logic                store_we;
    logic [2:0]          end_status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid      = m_valid_reg;
    assign m_ip_address = addr_reg;
    assign m_status     = status_reg;

    ipv4p_octet_check u_check (
        .octet (octet_reg),
        .err   (octet_err)
    );

    assign is_digit = (s_ch >= ipv4p_pkg::CH_ZERO) && (s_ch <= ipv4p_pkg::CH_NINE);
    assign digit    = 4'(s_ch - ipv4p_pkg::CH_ZERO);

    // Status at end of line: part count wins, then the earliest bad octet
    assign end_status = (dot_count_reg != ipv4p_pkg::LAST_DOT) ? ipv4p_pkg::ST_PARTS :
                        (first_err_reg != ipv4p_pkg::ST_OK)    ? first_err_reg :
                                                                  octet_err;

    always_comb begin
        skipping_next  = skipping_reg;
        dot_count_next = dot_count_reg;
        octet_next     = octet_reg;
        first_err_next = first_err_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        addr_next      = addr_reg;
        status_next    = status_reg;
        store_we       = 1'b0;

        if (accept && s_line_end) begin
            m_valid_next = 1'b1;
            status_next  = end_status;
            addr_next    = (end_status == ipv4p_pkg::ST_OK) ?
                           {store_reg[0], store_reg[1], store_reg[2], octet_reg.value[7:0]} :
                           32'd0;
            // back to start of line
            skipping_next  = 1'b0;
            dot_count_next = 3'd0;
            first_err_next = ipv4p_pkg::ST_OK;
            octet_next     = '0;
        end else if (accept) begin
            if (skipping_reg || dot_count_reg >= ipv4p_pkg::PART_LIMIT) begin
                if (s_ch == delim_reg) begin
                    skipping_next = 1'b1;
                end
            end else if (s_ch == delim_reg) begin
                // delimiter test first: a dot delimiter does not split
                skipping_next = 1'b1;
            end else if (s_ch == ipv4p_pkg::CH_DOT) begin
                if (first_err_reg == ipv4p_pkg::ST_OK) begin
                    first_err_next = octet_err;
                end
                store_we       = dot_count_reg < ipv4p_pkg::LAST_DOT;
                dot_count_next = dot_count_reg + 3'd1;
                octet_next     = '0;
            end else begin
                if (is_digit) begin
                    // value stays below 100 here, so 10 bits hold the result
                    if (octet_reg.length < ipv4p_pkg::OCTET_DIGITS) begin
                        octet_next.value = 10'(octet_reg.value * ipv4p_pkg::DECIMAL_BASE)
                                         + {6'd0, digit};
                    end
                end else begin
                    octet_next.nondigit = 1'b1;
                end
                if (octet_reg.length < ipv4p_pkg::PART_LIMIT) begin
                    octet_next.length = octet_reg.length + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg     <= ipv4p_pkg::DELIM_RESET;
            skipping_reg  <= 1'b0;
            dot_count_reg <= 3'd0;
            octet_reg     <= '0;
            first_err_reg <= ipv4p_pkg::ST_OK;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                delim_reg <= cfg_wdata;
            end
            skipping_reg  <= skipping_next;
            dot_count_reg <= dot_count_next;
            octet_reg     <= octet_next;
            first_err_reg <= first_err_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        status_reg <= status_next;
        if (store_we) begin
            store_reg[dot_count_reg[1:0]] <= octet_reg.value[7:0];
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_err_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ipv4p_pkg::ST_OK) |-> (m_ip_address == 32'd0))
        else $error("error result with nonzero address");

    a_dot_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (dot_count_reg <= ipv4p_pkg::PART_LIMIT))
        else $error("dot count past saturation");

    a_len_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (octet_reg.length <= ipv4p_pkg::PART_LIMIT))
        else $error("octet length past saturation");

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_line_end) |=>
        (m_valid_reg && dot_count_reg == 3'd0 && !skipping_reg
         && first_err_reg == ipv4p_pkg::ST_OK && octet_reg.length == 3'd0))
        else $error("line state not cleared after end of line");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ipv4p_pkg::ST_OVER_255))
        else $error("status code out of range");

endmodule

`default_nettype wire
